[rtl/salc_pkg.sv]
package salc_pkg;

	localparam int ADDR_W = 32;
	localparam int TAG_W  = 30;
	localparam int SET_W  = 10;
	localparam int WAY_W  = 2;
	localparam int CNT_W  = 32;

	localparam int IDX_W  = 4;
	localparam int OFF_W  = 3;
	localparam int WCFG_W = 3;

	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	localparam logic [IDX_W-1:0] IDX_BITS_MAX = 4'd10;
	localparam logic [OFF_W-1:0] OFF_BITS_MIN = 3'd2;
	localparam logic [OFF_W-1:0] OFF_BITS_MAX = 3'd6;

	localparam logic [IDX_W-1:0]  IDX_BITS_RST  = 4'd10;
	localparam logic [OFF_W-1:0]  OFF_BITS_RST  = 3'd2;
	localparam logic [WCFG_W-1:0] WAYS_USE_RST  = 3'd1;

	typedef enum logic [1:0] {
		REG_INDEX_BITS  = 2'd0,
		REG_OFFSET_BITS = 2'd1,
		REG_WAYS_IN_USE = 2'd2
	} salc_reg_t;

	typedef struct packed {
		logic [IDX_W-1:0]  index_bits;
		logic [OFF_W-1:0]  offset_bits;
		logic [WCFG_W-1:0] ways_in_use;
	} salc_cfg_t;

	typedef struct packed {
		logic clr_wr;
		logic load;
		logic mod_step;
		logic rd_en;
		logic lookup;
		logic commit;
	} salc_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic mod_skip;
		logic mod_last;
		logic out_free;
	} salc_stat_t;

endpackage

[rtl/salc_req_if.sv]
interface salc_req_if;
	import salc_pkg::*;

	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] address;

	modport source (output valid, output address, input ready);
	modport sink (input valid, input address, output ready);
endinterface

[rtl/salc_rsp_if.sv]
interface salc_rsp_if;
	import salc_pkg::*;

	logic             valid;
	logic             ready;
	logic             hit;
	logic [SET_W-1:0] set_number;
	logic [WAY_W-1:0] way_number;
	logic [CNT_W-1:0] hit_total;
	logic [CNT_W-1:0] miss_total;

	modport source (
		output valid, output hit, output set_number, output way_number,
		output hit_total, output miss_total, input ready
	);
	modport sink (
		input valid, input hit, input set_number, input way_number,
		input hit_total, input miss_total, output ready
	);
endinterface

[rtl/salc_ram.sv]
module salc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[rtl/salc_ctrl.sv]
module salc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_ready,
	input  salc_pkg::salc_stat_t   stat,
	output salc_pkg::salc_cmd_t    cmd
);
	import salc_pkg::*;

	typedef enum logic [5:0] {
		ST_CLEAR  = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_REDUCE = 6'b000100,
		ST_READ   = 6'b001000,
		ST_LOOKUP = 6'b010000,
		ST_WRITE  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		state_d   = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = stat.mod_skip ? ST_READ : ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				cmd.mod_step = 1'b1;
				if (stat.mod_last) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = ST_WRITE;
			end
			ST_WRITE: begin
				// hold the update until the output register can take the result
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

[rtl/salc_dp.sv]
module salc_dp #(
	parameter int SETS = 1024,
	parameter int WAYS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  salc_pkg::salc_cfg_t             cfg,
	input  salc_pkg::salc_cmd_t             cmd,
	output salc_pkg::salc_stat_t            stat,
	input  logic [salc_pkg::ADDR_W-1:0]     address,
	input  logic                            rsp_ready,
	output logic                            rsp_valid,
	output logic                            rsp_hit,
	output logic [salc_pkg::SET_W-1:0]      rsp_set_number,
	output logic [salc_pkg::WAY_W-1:0]      rsp_way_number,
	output logic [salc_pkg::CNT_W-1:0]      rsp_hit_total,
	output logic [salc_pkg::CNT_W-1:0]      rsp_miss_total
);
	import salc_pkg::*;

	localparam int AW      = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WIW     = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int RW      = WIW;
	localparam int NW      = $clog2(WAYS + 1);
	localparam int MW      = 2 * SET_W;
	localparam int PW      = SET_W + MW + 1;
	localparam bit NEED_MOD = SETS < (1 << SET_W);
	localparam logic [PW-1:0] RECIP = PW'((1 << MW) / SETS);

	typedef struct packed {
		logic [WAYS-1:0][RW-1:0] rank;
		logic [WAYS-1:0]         valid;
	} row_t;

	localparam int ROW_W  = $bits(row_t);
	localparam int TROW_W = WAYS * TAG_W;

	logic [AW-1:0]           clr_addr_q;
	logic [SET_W-1:0]        rem_q;
	logic [TAG_W-1:0]        tag_q;
	logic                    step_q;
	logic [SET_W-1:0]        quo_q;

	logic [IDX_W-1:0]        ib;
	logic [OFF_W-1:0]        ob;
	logic [4:0]              sh;
	logic [SET_W-1:0]        set_raw;
	logic [TAG_W-1:0]        tag_in;
	logic [PW-1:0]           prod;
	logic [MW-1:0]           fold;
	logic [SET_W-1:0]        diff;
	logic [NW-1:0]           n;

	row_t                    st_rd, st_new, st_new_q, clr_row, st_wdata;
	logic [WAYS-1:0][TAG_W-1:0] tag_rd, tag_new, tag_new_q;
	logic                    st_we;
	logic [AW-1:0]           st_waddr;

	logic [WAYS-1:0]         match;
	logic                    hit, hit_q;
	logic [WIW-1:0]          hit_way, lru_way, way, way_q;
	logic [RW:0]             best;
	logic [RW-1:0]           r;

	logic [CNT_W-1:0]        hit_cnt_q, miss_cnt_q;
	logic                    out_valid_q, out_hit_q;
	logic [SET_W-1:0]        out_set_q;
	logic [WAY_W-1:0]        out_way_q;

	// address split with clamped field sizes
	always_comb begin
		ib      = (cfg.index_bits > IDX_BITS_MAX) ? IDX_BITS_MAX : cfg.index_bits;
		if (cfg.offset_bits < OFF_BITS_MIN) begin
			ob = OFF_BITS_MIN;
		end else if (cfg.offset_bits > OFF_BITS_MAX) begin
			ob = OFF_BITS_MAX;
		end else begin
			ob = cfg.offset_bits;
		end
		sh      = 5'(ob) + 5'(ib);
		set_raw = SET_W'(address >> ob) & ~({SET_W{1'b1}} << ib);
		tag_in  = TAG_W'(address >> sh);
	end

	always_comb begin
		if (cfg.ways_in_use == '0) begin
			n = NW'(1);
		end else if (int'(cfg.ways_in_use) > WAYS) begin
			n = NW'(WAYS);
		end else begin
			n = NW'(cfg.ways_in_use);
		end
	end

	// reduce the set index modulo SETS: reciprocal estimate of the quotient
	// (low by at most one), then fold back and trim one SETS if needed
	assign prod = PW'(rem_q) * RECIP;
	assign fold = MW'(quo_q) * MW'(SETS);
	assign diff = rem_q - SET_W'(fold);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q  <= set_raw;
			tag_q  <= tag_in;
			step_q <= 1'b0;
		end else if (cmd.mod_step) begin
			if (!step_q) begin
				quo_q <= SET_W'(prod >> MW);
			end else if (MW'(diff) >= MW'(SETS)) begin
				rem_q <= SET_W'(MW'(diff) - MW'(SETS));
			end else begin
				rem_q <= diff;
			end
			step_q <= 1'b1;
		end
	end

	always_comb begin
		clr_row.valid = '0;
		for (int w = 0; w < WAYS; w++) begin
			clr_row.rank[w] = RW'(w);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	// compare, pick victim, re-rank
	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			match[w] = (NW'(w) < n) && st_rd.valid[w] && (tag_rd[w] == tag_q);
		end
		hit     = |match;
		hit_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (match[w]) begin
				hit_way = WIW'(w);
			end
		end
		best    = '1;
		lru_way = '0;
		for (int w = 0; w < WAYS; w++) begin
			if ((NW'(w) < n) && ({1'b0, st_rd.rank[w]} < best)) begin
				best    = {1'b0, st_rd.rank[w]};
				lru_way = WIW'(w);
			end
		end
		way     = hit ? hit_way : lru_way;
		r       = st_rd.rank[way];
		st_new  = st_rd;
		tag_new = tag_rd;
		for (int w = 0; w < WAYS; w++) begin
			if (WIW'(w) == way) begin
				st_new.rank[w] = RW'(WAYS - 1);
			end else if (st_rd.rank[w] > r) begin
				st_new.rank[w] = st_rd.rank[w] - RW'(1);
			end
		end
		if (!hit) begin
			st_new.valid[way] = 1'b1;
			tag_new[way]      = tag_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			hit_q     <= hit;
			way_q     <= way;
			st_new_q  <= st_new;
			tag_new_q <= tag_new;
		end
	end

	assign st_we    = cmd.clr_wr | cmd.commit;
	assign st_waddr = cmd.clr_wr ? clr_addr_q : AW'(rem_q);
	assign st_wdata = cmd.clr_wr ? clr_row : st_new_q;

	salc_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_state_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (cmd.rd_en),
		.raddr (AW'(rem_q)),
		.rdata (st_rd)
	);

	salc_ram #(.WIDTH(TROW_W), .DEPTH(SETS)) u_tag_ram (
		.clk   (clk),
		.we    (cmd.commit && !hit_q),
		.waddr (AW'(rem_q)),
		.wdata (tag_new_q),
		.re    (cmd.rd_en),
		.raddr (AW'(rem_q)),
		.rdata (tag_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
				if (hit_q && (hit_cnt_q != '1)) begin
					hit_cnt_q <= hit_cnt_q + CNT_W'(1);
				end
				if (!hit_q && (miss_cnt_q != '1)) begin
					miss_cnt_q <= miss_cnt_q + CNT_W'(1);
				end
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_hit_q <= hit_q;
			out_set_q <= rem_q;
			out_way_q <= WAY_W'(way_q);
		end
	end

	// counters only move on commit, so they stay put while a result is held
	assign rsp_valid      = out_valid_q;
	assign rsp_hit        = out_hit_q;
	assign rsp_set_number = out_set_q;
	assign rsp_way_number = out_way_q;
	assign rsp_hit_total  = hit_cnt_q;
	assign rsp_miss_total = miss_cnt_q;

	assign stat.clr_last = (clr_addr_q == AW'(SETS - 1));
	assign stat.mod_skip = !NEED_MOD;
	assign stat.mod_last = step_q;
	assign stat.out_free = !out_valid_q || rsp_ready;
endmodule

[rtl/set_assoc_lru_cache_tags.sv]
// channel   dir   handshake          beat payload
// req       in    valid / ready      address
// rsp       out   valid / ready      hit, set_number, way_number, hit_total, miss_total
// apb       in    psel/penable/pwrite index_bits @0, offset_bits @4, ways_in_use @8
//
// One address passes through accept, state RAM read, compare and write back when
// SETS >= 1024; otherwise the set index is first reduced modulo SETS by a
// reciprocal multiply and a fold-back step, before the read.
// One access at a time holds the read-modify-write of a set row. After reset a
// clearing pass over all SETS rows resets valid bits and recency ranks; req.ready
// stays low meanwhile.
// A result waits in the output register; the next access is taken meanwhile
// and only its write back stalls until rsp takes the held beat.
module set_assoc_lru_cache_tags #(
	parameter int SETS = 1024,
	parameter int WAYS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	salc_req_if.sink                      req,
	salc_rsp_if.source                    rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [salc_pkg::APB_AW-1:0]   paddr,
	input  logic [salc_pkg::APB_DW-1:0]   pwdata,
	output logic [salc_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);
	import salc_pkg::*;

	salc_cfg_t  cfg_q;
	salc_cmd_t  cmd;
	salc_stat_t stat;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.index_bits  <= IDX_BITS_RST;
			cfg_q.offset_bits <= OFF_BITS_RST;
			cfg_q.ways_in_use <= WAYS_USE_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_INDEX_BITS:  cfg_q.index_bits  <= pwdata[IDX_W-1:0];
				REG_OFFSET_BITS: cfg_q.offset_bits <= pwdata[OFF_W-1:0];
				REG_WAYS_IN_USE: cfg_q.ways_in_use <= pwdata[WCFG_W-1:0];
				default: begin
					// drop writes beyond the register list
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_INDEX_BITS:  prdata = APB_DW'(cfg_q.index_bits);
			REG_OFFSET_BITS: prdata = APB_DW'(cfg_q.offset_bits);
			REG_WAYS_IN_USE: prdata = APB_DW'(cfg_q.ways_in_use);
			default:         prdata = '0;
		endcase
	end

	salc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	salc_dp #(.SETS(SETS), .WAYS(WAYS)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.cmd            (cmd),
		.stat           (stat),
		.address        (req.address),
		.rsp_ready      (rsp.ready),
		.rsp_valid      (rsp.valid),
		.rsp_hit        (rsp.hit),
		.rsp_set_number (rsp.set_number),
		.rsp_way_number (rsp.way_number),
		.rsp_hit_total  (rsp.hit_total),
		.rsp_miss_total (rsp.miss_total)
	);
endmodule

[rtl/salc_check.sv]
module salc_check (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic                        rsp_hit,
	input logic [salc_pkg::SET_W-1:0]  rsp_set_number,
	input logic [salc_pkg::WAY_W-1:0]  rsp_way_number,
	input logic [salc_pkg::CNT_W-1:0]  rsp_hit_total,
	input logic [salc_pkg::CNT_W-1:0]  rsp_miss_total
);
	import salc_pkg::*;

	// a held result keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_hit, rsp_set_number,
			rsp_way_number, rsp_hit_total, rsp_miss_total}))
		else $error("rsp payload changed while stalled");

	// one access at a time: no back-to-back request beats
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while an access is in flight");

	a_hit_counted: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_hit |-> rsp_hit_total != '0)
		else $error("hit reported with zero hit count");

	a_miss_counted: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_hit |-> rsp_miss_total != '0)
		else $error("miss reported with zero miss count");
endmodule

bind set_assoc_lru_cache_tags salc_check u_check (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_hit        (rsp.hit),
	.rsp_set_number (rsp.set_number),
	.rsp_way_number (rsp.way_number),
	.rsp_hit_total  (rsp.hit_total),
	.rsp_miss_total (rsp.miss_total)
);

[sim/set_assoc_lru_cache_tags_tb.sv]
module set_assoc_lru_cache_tags_tb;
	import salc_pkg::*;

	localparam int NSETS       = 1024;
	localparam int NWAYS       = 4;
	localparam int LIMIT       = 200000;
	localparam int RAND_PHASES = 10;
	localparam int PHASE_ITEMS = 200;
	localparam int TAIL        = 20;
	localparam int DIR_ROWS    = 28;

	localparam logic [1:0] REG_SPARE = 2'd3;

	typedef enum logic { ROW_WRITE, ROW_LOOK } row_kind_t;

	typedef struct packed {
		logic             hit;
		logic [SET_W-1:0] set_number;
		logic [WAY_W-1:0] way_number;
		logic [CNT_W-1:0] hit_total;
		logic [CNT_W-1:0] miss_total;
	} lookup_t;

	typedef struct packed {
		row_kind_t         kind;
		logic [1:0]        regi;
		logic [ADDR_W-1:0] data;
		logic              chk;
		lookup_t           exp;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	salc_req_if req_bus ();
	salc_rsp_if rsp_bus ();

	set_assoc_lru_cache_tags uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_bus),
		.rsp     (rsp_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// shadow of the tag store
	logic             line_valid [NSETS][NWAYS];
	logic [TAG_W-1:0] line_tag   [NSETS][NWAYS];
	logic [WAY_W-1:0] line_rank  [NSETS][NWAYS];
	logic [CNT_W-1:0] hit_count;
	logic [CNT_W-1:0] miss_count;

	logic [IDX_W-1:0]  cfg_index_bits;
	logic [OFF_W-1:0]  cfg_offset_bits;
	logic [WCFG_W-1:0] cfg_ways;

	lookup_t pending_lookups [$];
	bit      mismatch_seen;
	int      cycle_cnt;

	row_t dir_rows [DIR_ROWS] = '{
		'{ROW_LOOK,  '0, 32'h0000_0000, 1'b1, '{1'b0, 10'd0,   2'd0, 32'd0, 32'd1}},
		'{ROW_LOOK,  '0, 32'h0000_0000, 1'b1, '{1'b1, 10'd0,   2'd0, 32'd1, 32'd1}},
		'{ROW_LOOK,  '0, 32'hFFFF_FFFF, 1'b1, '{1'b0, 10'h3FF, 2'd0, 32'd1, 32'd2}},
		'{ROW_LOOK,  '0, 32'hFFFF_FFFC, 1'b1, '{1'b1, 10'h3FF, 2'd0, 32'd2, 32'd2}},
		'{ROW_LOOK,  '0, 32'h0000_1000, 1'b1, '{1'b0, 10'd0,   2'd0, 32'd2, 32'd3}},
		'{ROW_LOOK,  '0, 32'h0000_0000, 1'b1, '{1'b0, 10'd0,   2'd0, 32'd2, 32'd4}},
		'{ROW_WRITE, REG_WAYS_IN_USE, 32'd4, 1'b0, '0},
		'{ROW_LOOK,  '0, 32'h0000_1024, 1'b0, '0},
		'{ROW_LOOK,  '0, 32'h0000_2024, 1'b0, '0},
		'{ROW_LOOK,  '0, 32'h0000_3024, 1'b0, '0},
		'{ROW_LOOK,  '0, 32'h0000_4024, 1'b0, '0},
		'{ROW_WRITE, REG_WAYS_IN_USE, 32'd1, 1'b0, '0},
		'{ROW_LOOK,  '0, 32'h0000_3024, 1'b0, '0},
		// tag now sits in way 0 and way 2; lowest way must win
		'{ROW_WRITE, REG_WAYS_IN_USE, 32'd7, 1'b0, '0},
		'{ROW_LOOK,  '0, 32'h0000_3024, 1'b0, '0},
		'{ROW_LOOK,  '0, 32'h0000_5024, 1'b0, '0},
		'{ROW_LOOK,  '0, 32'h0000_2024, 1'b0, '0},
		'{ROW_WRITE, REG_WAYS_IN_USE, 32'd0, 1'b0, '0},
		'{ROW_LOOK,  '0, 32'h0000_4024, 1'b0, '0},
		'{ROW_WRITE, REG_INDEX_BITS,  32'd15, 1'b0, '0},
		'{ROW_WRITE, REG_OFFSET_BITS, 32'd0, 1'b0, '0},
		'{ROW_LOOK,  '0, 32'h1234_5678, 1'b0, '0},
		'{ROW_WRITE, REG_INDEX_BITS,  32'd0, 1'b0, '0},
		'{ROW_WRITE, REG_OFFSET_BITS, 32'd7, 1'b0, '0},
		'{ROW_LOOK,  '0, 32'hFFFF_FFFF, 1'b0, '0},
		'{ROW_LOOK,  '0, 32'h0000_0000, 1'b0, '0},
		'{ROW_WRITE, REG_SPARE,       32'hFFFF_FFFF, 1'b0, '0},
		'{ROW_LOOK,  '0, 32'hDEAD_BEEF, 1'b0, '0}
	};

	function automatic bit calm();
		return cycle_cnt >= 3000 && cycle_cnt < 6000;
	endfunction

	function automatic lookup_t predict_lookup(input logic [ADDR_W-1:0] a);
		int unsigned ib;
		int unsigned ob;
		int unsigned n;
		int unsigned s;
		int unsigned way;
		int unsigned best;
		logic [TAG_W-1:0] t;
		logic [WAY_W-1:0] r;
		logic found;
		lookup_t res;
		ib = (cfg_index_bits > 10) ? 10 : cfg_index_bits;
		ob = (cfg_offset_bits < 2) ? 2 : ((cfg_offset_bits > 6) ? 6 : cfg_offset_bits);
		n = (cfg_ways == 0) ? 1 : ((cfg_ways > NWAYS) ? NWAYS : cfg_ways);
		s = ((a >> ob) & ((32'd1 << ib) - 32'd1)) % NSETS;
		t = TAG_W'(a >> (ob + ib));
		found = 1'b0;
		way = 0;
		for (int w = 0; w < n; w++) begin
			if (!found && line_valid[s][w] && line_tag[s][w] == t) begin
				found = 1'b1;
				way = w;
			end
		end
		if (found) begin
			if (hit_count != '1)
				hit_count++;
		end else begin
			best = NWAYS;
			for (int w = 0; w < n; w++) begin
				if (line_rank[s][w] < best) begin
					best = line_rank[s][w];
					way = w;
				end
			end
			line_valid[s][way] = 1'b1;
			line_tag[s][way] = t;
			if (miss_count != '1)
				miss_count++;
		end
		// promote to most recently used
		r = line_rank[s][way];
		for (int w = 0; w < NWAYS; w++) begin
			if (line_rank[s][w] > r)
				line_rank[s][w]--;
		end
		line_rank[s][way] = WAY_W'(NWAYS - 1);
		res.hit = found;
		res.set_number = SET_W'(s);
		res.way_number = WAY_W'(way);
		res.hit_total = hit_count;
		res.miss_total = miss_count;
		return res;
	endfunction

	task automatic write_reg(input logic [1:0] regi, input logic [APB_DW-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'({regi, 2'b00});
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (regi)
			REG_INDEX_BITS:  cfg_index_bits = data[IDX_W-1:0];
			REG_OFFSET_BITS: cfg_offset_bits = data[OFF_W-1:0];
			REG_WAYS_IN_USE: cfg_ways = data[WCFG_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic send_access(input logic [ADDR_W-1:0] a, input bit typed,
			input lookup_t typed_exp);
		lookup_t pred;
		psel <= 1'b0;
		penable <= 1'b0;
		while (!calm() && $urandom_range(99) < 6) begin
			req_bus.valid <= 1'b0;
			@(negedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.address <= a;
		@(posedge clk);
		while (!req_bus.ready)
			@(posedge clk);
		pred = predict_lookup(a);
		pending_lookups.push_back(typed ? typed_exp : pred);
		@(negedge clk);
	endtask

	// drop the request so the taken beat is not offered again
	task automatic wait_drained();
		req_bus.valid <= 1'b0;
		while (pending_lookups.size() != 0)
			@(negedge clk);
	endtask

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(negedge clk)
		if (arst_n)
			rsp_bus.ready <= calm() || $urandom_range(99) >= 6;

	always @(posedge clk) begin
		lookup_t want;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (pending_lookups.size() == 0) begin
				$error("result beat with nothing outstanding");
				mismatch_seen = 1'b1;
			end else begin
				want = pending_lookups.pop_front();
				if (rsp_bus.hit !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, rsp_bus.hit);
					mismatch_seen = 1'b1;
				end
				if (rsp_bus.set_number !== want.set_number) begin
					$error("set_number: expected %0d, got %0d",
						want.set_number, rsp_bus.set_number);
					mismatch_seen = 1'b1;
				end
				if (rsp_bus.way_number !== want.way_number) begin
					$error("way_number: expected %0d, got %0d",
						want.way_number, rsp_bus.way_number);
					mismatch_seen = 1'b1;
				end
				if (rsp_bus.hit_total !== want.hit_total) begin
					$error("hit_total: expected %0d, got %0d",
						want.hit_total, rsp_bus.hit_total);
					mismatch_seen = 1'b1;
				end
				if (rsp_bus.miss_total !== want.miss_total) begin
					$error("miss_total: expected %0d, got %0d",
						want.miss_total, rsp_bus.miss_total);
					mismatch_seen = 1'b1;
				end
			end
		end
	end

	initial begin
		int unsigned ib;
		int unsigned ob;
		logic [ADDR_W-1:0] a;
		logic [ADDR_W-1:0] imask;
		logic [ADDR_W-1:0] omask;
		logic [ADDR_W-1:0] tag_pool [6];
		logic [ADDR_W-1:0] set_pool [4];
		logic [IDX_W-1:0]  p_idx;
		logic [OFF_W-1:0]  p_off;
		logic [WCFG_W-1:0] p_ways;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_bus.valid = 1'b0;
		req_bus.address = '0;
		rsp_bus.ready = 1'b0;
		mismatch_seen = 1'b0;
		cycle_cnt = 0;
		for (int s = 0; s < NSETS; s++) begin
			for (int w = 0; w < NWAYS; w++) begin
				line_valid[s][w] = 1'b0;
				line_tag[s][w] = '0;
				line_rank[s][w] = WAY_W'(w);
			end
		end
		hit_count = '0;
		miss_count = '0;
		cfg_index_bits = IDX_BITS_RST;
		cfg_offset_bits = OFF_BITS_RST;
		cfg_ways = WAYS_USE_RST;

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_rows[i].kind == ROW_WRITE) begin
				wait_drained();
				write_reg(dir_rows[i].regi, dir_rows[i].data);
			end else begin
				send_access(dir_rows[i].data, dir_rows[i].chk, dir_rows[i].exp);
			end
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				0: begin p_idx = 4'd10; p_off = 3'd2; p_ways = 3'd4; end
				1: begin p_idx = 4'd0;  p_off = 3'd6; p_ways = 3'd1; end
				2: begin p_idx = 4'd15; p_off = 3'd7; p_ways = 3'd7; end
				3: begin p_idx = 4'd1;  p_off = 3'd0; p_ways = 3'd0; end
				4: begin p_idx = 4'd10; p_off = 3'd6; p_ways = 3'd2; end
				default: begin
					p_idx = IDX_W'($urandom_range(15));
					p_off = OFF_W'($urandom_range(7));
					p_ways = WCFG_W'($urandom_range(7));
				end
			endcase
			wait_drained();
			// junk in the upper data bits must be dropped
			write_reg(REG_INDEX_BITS, {28'($urandom()), p_idx});
			write_reg(REG_OFFSET_BITS, {29'($urandom()), p_off});
			write_reg(REG_WAYS_IN_USE, {29'($urandom()), p_ways});

			ib = (p_idx > 10) ? 10 : p_idx;
			ob = (p_off < 2) ? 2 : ((p_off > 6) ? 6 : p_off);
			imask = (32'd1 << ib) - 32'd1;
			omask = (32'd1 << ob) - 32'd1;
			// a few tags over a few sets, so lines get reused and evicted
			foreach (tag_pool[k])
				tag_pool[k] = $urandom();
			foreach (set_pool[k])
				set_pool[k] = $urandom() & imask;

			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(99) < 15)
					a = $urandom();
				else
					a = (tag_pool[$urandom_range(5)] << (ob + ib))
						| (set_pool[$urandom_range(3)] << ob)
						| ($urandom() & omask);
				send_access(a, 1'b0, '0);
			end
		end

		wait_drained();
		repeat (TAIL) @(negedge clk);
		if (!mismatch_seen)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
